### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the modulator RTL
// Implication checks with a synchronous active-high reset as disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds too.
`define FSK_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication: when ante holds, cons holds in the following cycle.
`define FSK_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/fsk_pkg.sv
// ---------------------------------------------------------------------------
// fsk_pkg
// Shared types and constants of the cassette FSK byte modulator.
// ---------------------------------------------------------------------------
package fsk_pkg;

   localparam int SAMPLE_W = 8;
   localparam logic [SAMPLE_W-1:0] SAMPLE_HIGH = {SAMPLE_W{1'b1}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_LOW  = '0;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MID  = {1'b1, {(SAMPLE_W-1){1'b0}}};

   localparam int DATA_W   = 8;
   localparam int CNT_W    = 8;
   localparam int STOP_W   = 3;
   localparam int LEADER_W = 20;
   localparam int FRAME_W  = 16;
   localparam int BITS_W   = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   // Request opcodes
   localparam logic [1:0] OP_TICK         = 2'd0;
   localparam logic [1:0] OP_LONG_LEADER  = 2'd1;
   localparam logic [1:0] OP_SHORT_LEADER = 2'd2;
   localparam logic [1:0] OP_SEND_BYTE    = 2'd3;

   // Activity modes of the back end
   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_LEADER = 2'd1;
   localparam logic [1:0] MODE_BYTE   = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_LENGTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_HALF    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_HALF     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_COUNT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_LEADER  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_LEADER = 3'd5;

   // Register reset values
   localparam logic [CNT_W-1:0]    RST_BIT_LENGTH   = 8'd16;
   localparam logic [CNT_W-1:0]    RST_ZERO_HALF    = 8'd8;
   localparam logic [CNT_W-1:0]    RST_ONE_HALF     = 8'd4;
   localparam logic [STOP_W-1:0]   RST_STOP_COUNT   = 3'd3;
   localparam logic [LEADER_W-1:0] RST_LONG_LEADER  = 20'd38400;
   localparam logic [LEADER_W-1:0] RST_SHORT_LEADER = 20'd9600;

   // Request queue between front and back
   localparam int QDEPTH = 2;
   localparam int QADDR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [CNT_W-1:0]    bit_length;
      logic [CNT_W-1:0]    zero_half;
      logic [CNT_W-1:0]    one_half;
      logic [STOP_W-1:0]   stop_count;
      logic [LEADER_W-1:0] long_leader;
      logic [LEADER_W-1:0] short_leader;
   } cfg_type;

   // A request after classification by the front end
   typedef struct packed {
      logic              start_long;
      logic              start_short;
      logic              send_byte;
      logic [DATA_W-1:0] data_byte;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                busy_res;
      logic                unit_last;
      logic                rejected;
   } rsp_type;

endpackage

### rtl/fsk_front.sv
// ---------------------------------------------------------------------------
// fsk_front
// Request intake: decodes each request and holds it in a short queue.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fsk_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_opcode,
   input  logic [fsk_pkg::DATA_W-1:0]   req_data_byte,
   output fsk_pkg::queue_head_type      head,
   input  logic                         pop
);
   import fsk_pkg::*;

   cmd_type              entry_ff [QDEPTH];
   logic [QADDR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QADDR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;
   logic                 push;
   logic                 do_pop;
   cmd_type              cmd_in;

   always_comb begin
      cmd_in.start_long  = (req_opcode == OP_LONG_LEADER);
      cmd_in.start_short = (req_opcode == OP_SHORT_LEADER);
      cmd_in.send_byte   = (req_opcode == OP_SEND_BYTE);
      cmd_in.data_byte   = req_data_byte;
   end

   assign req_stall = (count_ff == QCNT_W'(QDEPTH));
   assign push      = req_valid && !req_stall;
   assign do_pop    = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QADDR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QADDR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   `FSK_ASSERT_SAME(a_count_bounded, clock, reset, 1'b1, count_ff <= QCNT_W'(QDEPTH))
   `FSK_ASSERT_NEXT(a_full_holds, clock, reset, req_stall && !pop, req_stall)

endmodule

### rtl/fsk_back.sv
// ---------------------------------------------------------------------------
// fsk_back
// Modulator engine: runs leaders and byte frames, one sample per request.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fsk_back (
   input  logic                    clock,
   input  logic                    reset,
   input  fsk_pkg::cfg_type        cfg,
   input  fsk_pkg::queue_head_type head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output fsk_pkg::rsp_type        rsp
);
   import fsk_pkg::*;

   logic [1:0]          mode_ff, mode_in;
   logic [FRAME_W-1:0]  frame_ff, frame_in;
   logic [BITS_W-1:0]   bits_left_ff, bits_left_in;
   logic [CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [CNT_W-1:0]    half_ff, half_in;
   logic                level_ff, level_in;
   logic [LEADER_W-1:0] leader_ff, leader_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                is_cmd;
   logic                start_ok;
   logic [FRAME_W-1:0]  frame_low;
   logic [(1<<STOP_W)-1:0] stop_ones;
   logic [CNT_W-1:0]    period;
   logic [CNT_W-1:0]    half_next;
   logic [CNT_W-1:0]    bit_cnt_next;
   logic [BITS_W-1:0]   bits_dec;

   assign pop = head.valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      is_cmd    = head.cmd.start_long || head.cmd.start_short || head.cmd.send_byte;
      start_ok  = is_cmd && (mode_ff == MODE_IDLE);
      stop_ones = ~({(1<<STOP_W){1'b1}} << cfg.stop_count);
      frame_low = {stop_ones[(1<<STOP_W)-2:0], head.cmd.data_byte, 1'b0};

      mode_in      = mode_ff;
      frame_in     = frame_ff;
      bits_left_in = bits_left_ff;
      bit_cnt_in   = bit_cnt_ff;
      half_in      = half_ff;
      level_in     = level_ff;
      leader_in    = leader_ff;

      rsp_in.sample    = SAMPLE_MID;
      rsp_in.busy_res  = 1'b0;
      rsp_in.unit_last = 1'b0;
      rsp_in.rejected  = is_cmd && (mode_ff != MODE_IDLE);

      // A command taken while idle starts its unit and gives its first sample now.
      if (start_ok) begin
         level_in = 1'b1;
         half_in  = '0;
         if (head.cmd.send_byte) begin
            frame_in     = frame_low;
            bits_left_in = BITS_W'(9) + BITS_W'(cfg.stop_count);
            bit_cnt_in   = '0;
            mode_in      = MODE_BYTE;
         end else begin
            leader_in = head.cmd.start_long ? cfg.long_leader : cfg.short_leader;
            mode_in   = MODE_LEADER;
         end
      end

      period       = (mode_in == MODE_BYTE && !frame_in[0]) ? cfg.zero_half : cfg.one_half;
      half_next    = half_in + 1'b1;
      bit_cnt_next = bit_cnt_in + 1'b1;
      bits_dec     = bits_left_in - 1'b1;

      if (mode_in != MODE_IDLE) begin
         rsp_in.sample = level_in ? SAMPLE_HIGH : SAMPLE_LOW;
         if (half_next == period) begin
            level_in = !level_in;
            half_in  = '0;
         end else begin
            half_in = half_next;
         end
         if (mode_in == MODE_LEADER) begin
            if (leader_in == LEADER_W'(1)) begin
               rsp_in.unit_last = 1'b1;
               mode_in          = MODE_IDLE;
            end else begin
               leader_in = leader_in - 1'b1;
            end
         end else if (bit_cnt_next == cfg.bit_length) begin
            frame_in     = frame_in >> 1;
            bits_left_in = bits_dec;
            bit_cnt_in   = '0;
            if (bits_dec == '0) begin
               rsp_in.unit_last = 1'b1;
               mode_in          = MODE_IDLE;
            end else begin
               level_in = 1'b1;
               half_in  = '0;
            end
         end else begin
            bit_cnt_in = bit_cnt_next;
         end
         rsp_in.busy_res = (mode_in != MODE_IDLE);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         frame_ff     <= '0;
         bits_left_ff <= '0;
         bit_cnt_ff   <= '0;
         half_ff      <= '0;
         level_ff     <= 1'b1;
         leader_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            mode_ff      <= mode_in;
            frame_ff     <= frame_in;
            bits_left_ff <= bits_left_in;
            bit_cnt_ff   <= bit_cnt_in;
            half_ff      <= half_in;
            level_ff     <= level_in;
            leader_ff    <= leader_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `FSK_ASSERT_SAME(a_byte_has_bits, clock, reset, mode_ff == MODE_BYTE, bits_left_ff != '0)
   `FSK_ASSERT_SAME(a_last_ends_unit, clock, reset, rsp_valid_ff && rsp_ff.unit_last,
                    !rsp_ff.busy_res && (mode_ff == MODE_IDLE || !$past(pop) || $past(reset)))
   `FSK_ASSERT_SAME(a_mid_when_idle, clock, reset, rsp_valid_ff && rsp_ff.sample == SAMPLE_MID,
                    !rsp_ff.busy_res && !rsp_ff.unit_last)

endmodule

### rtl/fsk_tape_byte_modulator_unit.sv
// ---------------------------------------------------------------------------
// fsk_tape_byte_modulator_unit
// Path: a request passes the request queue, then the result register, before
// its sample is on rsp_valid.
// Throughput: one request per cycle while the result channel is not stalled.
// The two-entry request queue lets intake continue while a result is stalled.
// Reset (synchronous, active high) empties the queue, idles the engine and
// loads the default timing registers.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fsk_tape_byte_modulator_unit (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_opcode,
   input  logic [fsk_pkg::DATA_W-1:0]       req_data_byte,
   // Result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [fsk_pkg::SAMPLE_W-1:0]     rsp_sample,
   output logic                             rsp_busy_res,
   output logic                             rsp_unit_last,
   output logic                             rsp_rejected,
   // Register write port
   input  logic                             csr_we,
   input  logic [fsk_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fsk_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import fsk_pkg::*;

   // The timing registers. A new value is used from the next request that the
   // engine takes, also in the middle of a running leader or byte.
   cfg_type        cfg_ff, cfg_in;
   queue_head_type head;
   logic           pop;
   rsp_type        rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BIT_LENGTH:   cfg_in.bit_length   = csr_wdata[CNT_W-1:0];
            CSR_ZERO_HALF:    cfg_in.zero_half    = csr_wdata[CNT_W-1:0];
            CSR_ONE_HALF:     cfg_in.one_half     = csr_wdata[CNT_W-1:0];
            CSR_STOP_COUNT:   cfg_in.stop_count   = csr_wdata[STOP_W-1:0];
            CSR_LONG_LEADER:  cfg_in.long_leader  = csr_wdata[LEADER_W-1:0];
            CSR_SHORT_LEADER: cfg_in.short_leader = csr_wdata[LEADER_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_length   <= RST_BIT_LENGTH;
         cfg_ff.zero_half    <= RST_ZERO_HALF;
         cfg_ff.one_half     <= RST_ONE_HALF;
         cfg_ff.stop_count   <= RST_STOP_COUNT;
         cfg_ff.long_leader  <= RST_LONG_LEADER;
         cfg_ff.short_leader <= RST_SHORT_LEADER;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: decodes each request into start and send flags and queues it.
   // The queue decouples intake from the engine, so a stalled result does not
   // immediately stall the request side.
   fsk_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_data_byte (req_data_byte),
      .head          (head),
      .pop           (pop)
   );

   // Back end: takes one queued request per cycle whenever its output register
   // is free or being emptied, advances the wave and frame counters and
   // registers the resulting sample together with its status flags.
   fsk_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_sample    = rsp.sample;
   assign rsp_busy_res  = rsp.busy_res;
   assign rsp_unit_last = rsp.unit_last;
   assign rsp_rejected  = rsp.rejected;

   // A result that is still waiting must not be overwritten by the engine.
   `FSK_ASSERT_SAME(a_no_overwrite, clock, reset, rsp_valid && rsp_stall, !pop)

endmodule
